/* rtl/core/plbe_pkg.sv */
// Package with the transaction types, register map and constants of the pixel LSB byte embedder.
package plbe_pkg;

	localparam int HEADER_BYTES = 8;
	localparam int HPOS_W       = $clog2(HEADER_BYTES + 1);
	localparam int LEN_W        = 64;
	localparam int DATA_W       = 64;
	localparam int ADDR_W       = 4;

	localparam logic REG_MODE   = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	localparam logic MODE_EXTRACT = 1'b0;
	localparam logic MODE_EMBED   = 1'b1;

	localparam logic [7:0] KEEP_RB = 8'hF8;
	localparam logic [7:0] KEEP_G  = 8'hFC;

	typedef struct packed {
		logic       frame_start;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] data_byte;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_byte;
		logic       byte_flag;
		logic       done_res;
	} result_t;

endpackage

/* rtl/core/pixel_lsb_byte_embedder.sv */
// Top level of the pixel LSB byte embedder: register port, embed and extract datapath.
// A pixel's result is registered: it is valid just after the clock edge that accepts the pixel.
// Throughput: one pixel per cycle unless a held result waits; taking it frees the register.
// Frame state (header count, length, byte count, done flag) is updated as each pixel is accepted.
// Reset clears the mode and length registers, the frame state and the result valid flag.
// After reset the first pixel is handled as the first header pixel of a fresh frame.
module pixel_lsb_byte_embedder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [plbe_pkg::ADDR_W-1:0]   paddr,
	input  logic [plbe_pkg::DATA_W-1:0]   pwdata,
	output logic [plbe_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  plbe_pkg::pixel_t              pixel,
	output logic                          result_valid,
	input  logic                          result_ready,
	output plbe_pkg::result_t             result
);
	import plbe_pkg::*;

	logic                mode_q;
	logic [LEN_W-1:0]    length_q;
	logic [HPOS_W-1:0]   hpos_q;
	logic [LEN_W-1:0]    lshift_q;
	logic [LEN_W-1:0]    bytes_done_q;
	logic                finished_q;
	logic                result_valid_q;
	result_t             result_q;

	logic                wr_en;
	logic                take;
	logic [HPOS_W-1:0]   hpos_cur;
	logic [LEN_W-1:0]    lshift_cur;
	logic [LEN_W-1:0]    bytes_done_cur;
	logic                finished_cur;
	logic [HPOS_W-1:0]   hpos_nxt;
	logic [LEN_W-1:0]    lshift_nxt;
	logic [LEN_W-1:0]    bytes_done_nxt;
	logic                finished_nxt;
	logic [LEN_W-1:0]    bytes_inc;
	logic [7:0]          got;
	logic [7:0]          carried;
	logic [7:0]          len_byte;
	logic [2:0]          byte_sel;
	logic                in_header;
	result_t             res_nxt;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[3])
			REG_MODE:   prdata = {{(DATA_W-1){1'b0}}, mode_q};
			REG_LENGTH: prdata = length_q;
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_EXTRACT;
			length_q <= '0;
		end else if (wr_en) begin
			case (paddr[3])
				REG_MODE:   mode_q   <= pwdata[0];
				REG_LENGTH: length_q <= pwdata;
				default:    ;
			endcase
		end
	end

	assign pixel_ready  = !result_valid_q || result_ready;
	assign take         = pixel_valid && pixel_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		if (pixel.frame_start) begin
			hpos_cur       = '0;
			lshift_cur     = '0;
			bytes_done_cur = '0;
			finished_cur   = 1'b0;
		end else begin
			hpos_cur       = hpos_q;
			lshift_cur     = lshift_q;
			bytes_done_cur = bytes_done_q;
			finished_cur   = finished_q;
		end

		got       = {pixel.red[2:0], pixel.green[1:0], pixel.blue[2:0]};
		byte_sel  = 3'(HEADER_BYTES - 1 - int'(hpos_cur));
		len_byte  = length_q[8*byte_sel +: 8];
		in_header = hpos_cur < HPOS_W'(HEADER_BYTES);
		bytes_inc = bytes_done_cur + LEN_W'(1);

		if (mode_q == MODE_EMBED) begin
			carried = in_header ? len_byte : pixel.data_byte;
		end else begin
			carried = got;
		end

		hpos_nxt       = hpos_cur;
		lshift_nxt     = lshift_cur;
		bytes_done_nxt = bytes_done_cur;
		finished_nxt   = finished_cur;

		res_nxt.out_red   = pixel.red;
		res_nxt.out_green = pixel.green;
		res_nxt.out_blue  = pixel.blue;
		res_nxt.out_byte  = '0;
		res_nxt.byte_flag = 1'b0;

		if (!finished_cur) begin
			if (in_header) begin
				lshift_nxt = {lshift_cur[LEN_W-9:0], carried};
				hpos_nxt   = hpos_cur + HPOS_W'(1);
				if (hpos_nxt == HPOS_W'(HEADER_BYTES) && lshift_nxt == '0) begin
					finished_nxt = 1'b1;
				end
			end else begin
				res_nxt.byte_flag = 1'b1;
				bytes_done_nxt    = bytes_inc;
				if (bytes_inc >= lshift_cur) begin
					finished_nxt = 1'b1;
				end
			end

			if (mode_q == MODE_EMBED) begin
				res_nxt.out_red   = (pixel.red & KEEP_RB) | {5'd0, carried[7:5]};
				res_nxt.out_green = (pixel.green & KEEP_G) | {6'd0, carried[4:3]};
				res_nxt.out_blue  = (pixel.blue & KEEP_RB) | {5'd0, carried[2:0]};
			end else begin
				res_nxt.out_byte = got;
			end
		end

		res_nxt.done_res = finished_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpos_q         <= '0;
			lshift_q       <= '0;
			bytes_done_q   <= '0;
			finished_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				hpos_q         <= hpos_nxt;
				lshift_q       <= lshift_nxt;
				bytes_done_q   <= bytes_done_nxt;
				finished_q     <= finished_nxt;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= res_nxt;
		end
	end

endmodule

/* tb/sv/pixel_lsb_byte_embedder_tb.sv */
// Testbench for the pixel LSB byte embedder: directed and random pixel streams checked by a scoreboard.
`timescale 1ns / 100ps

module pixel_lsb_byte_embedder_tb;
	import plbe_pkg::*;

	localparam logic [ADDR_W-1:0] ADDR_MODE   = {REG_MODE, 3'b000};
	localparam logic [ADDR_W-1:0] ADDR_LENGTH = {REG_LENGTH, 3'b000};
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 1750;
	localparam int IDLE_PERCENT = 21;
	localparam int HOLD_AT      = 1800;
	localparam int HOLD_LEN     = 300;
	localparam int MAX_BODY     = 40;

	class lsb_scoreboard;
		logic              mode_q;
		logic [LEN_W-1:0]  length_reg;
		logic [HPOS_W-1:0] header_count;
		logic [LEN_W-1:0]  length_acc;
		logic [LEN_W-1:0]  bytes_handled;
		bit                complete;
		result_t           expected_pixels[$];
		int                errors;

		function new();
			mode_q = MODE_EXTRACT;
			length_reg = '0;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			header_count = '0;
			length_acc = '0;
			bytes_handled = '0;
			complete = 1'b0;
		endfunction

		function void write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
			if (addr == ADDR_MODE) begin
				mode_q = data[0];
			end else if (addr == ADDR_LENGTH) begin
				length_reg = data;
			end
		endfunction

		function void note_pixel(pixel_t p);
			result_t    r;
			logic [7:0] got;
			logic [7:0] carried;
			bit         embedding;
			int         shift;
			embedding = (mode_q == MODE_EMBED);
			if (p.frame_start) begin
				clear_frame();
			end
			r.out_red = p.red;
			r.out_green = p.green;
			r.out_blue = p.blue;
			r.out_byte = '0;
			r.byte_flag = 1'b0;
			if (!complete) begin
				got = {p.red[2:0], p.green[1:0], p.blue[2:0]};
				if (header_count < HEADER_BYTES) begin
					shift = 8 * (HEADER_BYTES - 1 - int'(header_count));
					carried = embedding ? 8'(length_reg >> shift) : got;
					length_acc = (length_acc << 8) | LEN_W'(carried);
					header_count++;
					if (header_count == HEADER_BYTES && length_acc == '0) begin
						complete = 1'b1;
					end
				end else begin
					carried = embedding ? p.data_byte : got;
					r.byte_flag = 1'b1;
					bytes_handled++;
					if (bytes_handled >= length_acc) begin
						complete = 1'b1;
					end
				end
				if (embedding) begin
					r.out_red = {p.red[7:3], carried[7:5]};
					r.out_green = {p.green[7:2], carried[4:3]};
					r.out_blue = {p.blue[7:3], carried[2:0]};
				end else begin
					r.out_byte = got;
				end
			end
			r.done_res = complete;
			expected_pixels.push_back(r);
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_pixels.size() == 0) begin
				$display("%0t: result %h arrived with nothing expected", $time, got);
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("out_red", want.out_red, got.out_red);
			compare_field("out_green", want.out_green, got.out_green);
			compare_field("out_blue", want.out_blue, got.out_blue);
			compare_field("out_byte", want.out_byte, got.out_byte);
			compare_field("byte_flag", 8'(want.byte_flag), 8'(got.byte_flag));
			compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              pixel_valid = 1'b0;
	logic              pixel_ready;
	pixel_t            pixel = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	result_t           result;

	lsb_scoreboard lsb_sb = new();
	bit            steady = 1'b0;
	int            cycles = 0;
	int            pixels_sent = 0;

	pixel_lsb_byte_embedder dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				lsb_sb.write_reg(paddr, pwdata);
			end
			if (pixel_valid && pixel_ready) begin
				lsb_sb.note_pixel(pixel);
			end
			if (result_valid && result_ready) begin
				lsb_sb.check_result(result);
			end
		end
	end

	initial begin : receiver
		int recv_cycles;
		recv_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			recv_cycles++;
			if (recv_cycles >= HOLD_AT && recv_cycles < HOLD_AT + HOLD_LEN) begin
				result_ready <= 1'b0;
			end else begin
				result_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	task automatic send_pixel(input pixel_t p);
		logic took;
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= p;
		do begin
			@(negedge clk);
			took = pixel_ready;
			@(posedge clk);
		end while (!took);
		pixels_sent++;
	endtask

	task automatic wait_idle();
		pixel_valid <= 1'b0;
		@(negedge clk);
		while (lsb_sb.expected_pixels.size() != 0) begin
			@(negedge clk);
		end
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		logic took;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			took = pready;
			@(posedge clk);
		end while (!took);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input bit embedding, input logic [LEN_W-1:0] len);
		wait_idle();
		apb_write(ADDR_MODE, DATA_W'(embedding ? MODE_EMBED : MODE_EXTRACT));
		apb_write(ADDR_LENGTH, DATA_W'(len));
	endtask

	function automatic pixel_t carrier_pixel(bit fs, logic [7:0] b);
		pixel_t p;
		p.frame_start = fs;
		p.red = {5'($urandom), b[7:5]};
		p.green = {6'($urandom), b[4:3]};
		p.blue = {5'($urandom), b[2:0]};
		p.data_byte = 8'($urandom);
		return p;
	endfunction

	// In extract mode the header pixels carry the given length; other pixels carry random bytes.
	task automatic send_frame(input bit embedding, input logic [LEN_W-1:0] len, input int from,
			input int count, input bit fs);
		logic [7:0] b;
		for (int i = from; i < from + count; i++) begin
			if (!embedding && i < HEADER_BYTES) begin
				b = 8'(len >> (8 * (HEADER_BYTES - 1 - i)));
			end else begin
				b = 8'($urandom);
			end
			send_pixel(carrier_pixel(fs && i == from, b));
		end
	endtask

	initial begin : stimulus
		int               pick;
		int               body;
		bit               embedding;
		logic [LEN_W-1:0] reg_len;
		logic [LEN_W-1:0] frame_len;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A fresh frame begins after reset even without a frame start.
		send_pixel('0);
		send_pixel('1);

		// Zero length finishes on the last header pixel; later pixels pass through.
		configure(1'b1, '0);
		send_frame(1'b1, '0, 0, HEADER_BYTES + 2, 1'b1);

		// Switch from embedding to extracting in the middle of a header.
		configure(1'b1, 64'd3);
		send_frame(1'b1, 64'd3, 0, 4, 1'b1);
		configure(1'b0, 64'd3);
		send_frame(1'b0, 64'd3, 4, 8, 1'b0);

		for (int phase = 0; pixels_sent < RANDOM_ITEMS; phase++) begin
			pick = $urandom_range(99);
			embedding = 1'($urandom_range(1));
			if (phase == 0) begin
				embedding = 1'b1;
				reg_len = '1;
			end else if (pick < 10) begin
				reg_len = '0;
			end else if (pick < 20) begin
				reg_len = '1;
			end else if (pick < 30) begin
				reg_len = {$urandom, $urandom};
			end else begin
				reg_len = LEN_W'($urandom_range(24, 1));
			end
			configure(embedding, reg_len);
			repeat ($urandom_range(4, 2)) begin
				steady = (pixels_sent >= 800 && pixels_sent < 1100);
				pick = $urandom_range(99);
				if (embedding) begin
					frame_len = reg_len;
				end else if (pick < 10) begin
					frame_len = {$urandom, $urandom};
				end else begin
					frame_len = LEN_W'($urandom_range(24));
				end
				body = (frame_len > MAX_BODY) ? MAX_BODY : int'(frame_len);
				if (pick >= 90) begin
					repeat ($urandom_range(20, 5)) begin
						send_pixel(carrier_pixel($urandom_range(7) == 0, 8'($urandom)));
					end
				end else if (pick >= 80) begin
					send_frame(embedding, frame_len, 0,
						$urandom_range(HEADER_BYTES + body, 1), 1'b1);
				end else begin
					send_frame(embedding, frame_len, 0,
						HEADER_BYTES + body + $urandom_range(4), 1'b1);
				end
			end
		end
		steady = 1'b0;

		wait_idle();
		repeat (8) @(posedge clk);
		if (lsb_sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
